[hw/rtl/bbse_pkg.sv]
// Shared types and constants for the bicubic Bezier surface evaluator.
package bbse_pkg;

    localparam int COORD_BITS = 16;
    localparam int PARAM_BITS = 16;
    localparam int NUM_POINTS = 16;
    localparam int IDX_BITS   = $clog2(NUM_POINTS);
    localparam int SIDE_BITS  = IDX_BITS / 2;
    localparam int WFRAC      = 30;
    localparam int WGT_BITS   = WFRAC + 1;
    localparam int PROD_BITS  = WGT_BITS + 1 + COORD_BITS;
    localparam int ACC_BITS   = PROD_BITS + IDX_BITS;
    localparam int WGT_WAIT   = 1;

    localparam logic [PARAM_BITS-1:0] ONE_Q15 = PARAM_BITS'(32768);

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WGT,
        ST_WALK,
        ST_DRAIN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    typedef struct packed {
        op_t                          op;
        logic [SIDE_BITS-1:0]         point_row;
        logic [SIDE_BITS-1:0]         point_col;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic [PARAM_BITS-1:0]        param_u;
        logic [PARAM_BITS-1:0]        param_v;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] surf_x;
        logic signed [COORD_BITS-1:0] surf_y;
        logic signed [COORD_BITS-1:0] surf_z;
    } out_word_t;

    typedef struct packed {
        logic                clr;
        logic                issue;
        logic                last;
        logic [IDX_BITS-1:0] idx;
    } mac_ctl_t;

    typedef logic [3:0][WGT_BITS-1:0] wgt_vec_t;

endpackage

[hw/rtl/bbse_in_if.sv]
// Input channel: valid/ready handshake carrying one input word.
interface bbse_in_if;
    logic                valid;
    logic                ready;
    bbse_pkg::in_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/bbse_out_if.sv]
// Output channel: valid/ready handshake carrying one surface point word.
interface bbse_out_if;
    logic                valid;
    logic                ready;
    bbse_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/bicubic_bezier_surface_eval.sv]
// Bicubic Bezier surface evaluator: control, store, weights, MAC and output register.
// A load word is written to the point store at the edge that accepts it.
// An evaluate word passes through the weight wait, the walk over the point store (one
// read port access per point), the MAC drain and the output load; the next word is
// taken only back in idle, and the output load stalls while the last result is unread.
// Reset clears control and the output valid; the point store is undefined until loaded.
module bicubic_bezier_surface_eval (
    input  logic        clk,
    input  logic        rst_n,
    bbse_in_if.sink     item,
    bbse_out_if.source  result
);

    localparam int IB = bbse_pkg::IDX_BITS;
    localparam int AB = bbse_pkg::ACC_BITS;
    localparam int CB = bbse_pkg::COORD_BITS;
    localparam logic [IB-1:0] LAST_IDX = IB'(bbse_pkg::NUM_POINTS - 1);
    localparam logic [IB-1:0] WGT_LAST = IB'(bbse_pkg::WGT_WAIT);
    localparam logic signed [AB-1:0] RND_HALF  = AB'(1) << (bbse_pkg::WFRAC - 1);
    localparam logic signed [AB-1:0] COORD_MAX = AB'((2 ** (CB - 1)) - 1);
    localparam logic signed [AB-1:0] COORD_MIN = AB'(-(2 ** (CB - 1)));

    bbse_pkg::state_t    state_reg;
    bbse_pkg::state_t    state_next;
    logic [IB-1:0]       cnt_reg;
    logic [IB-1:0]       cnt_next;
    logic                accept;
    logic                is_eval;
    logic                mem_we;
    logic                out_load;
    logic                out_valid_reg;
    bbse_pkg::out_word_t out_data_reg;
    bbse_pkg::out_word_t out_data_next;
    bbse_pkg::mac_ctl_t  mac_ctl;
    bbse_pkg::wgt_vec_t  wu;
    bbse_pkg::wgt_vec_t  wv;
    bbse_pkg::point_t    wr_point;
    bbse_pkg::point_t    rd_point;
    logic signed [AB-1:0] acc_x;
    logic signed [AB-1:0] acc_y;
    logic signed [AB-1:0] acc_z;
    logic                mac_done;

    function automatic logic signed [CB-1:0] round_sat(input logic signed [AB-1:0] acc);
        logic signed [AB-1:0] biased;
        logic signed [AB-1:0] r;
        biased = acc + RND_HALF;
        r = biased >>> bbse_pkg::WFRAC;
        if (r > COORD_MAX)
        begin
            r = COORD_MAX;
        end
        else if (r < COORD_MIN)
        begin
            r = COORD_MIN;
        end
        return CB'(r);
    endfunction

    assign item.ready = (state_reg == bbse_pkg::ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign is_eval    = (item.data.op == bbse_pkg::OP_EVAL);
    assign mem_we     = accept && !is_eval;

    assign wr_point.x = item.data.coord_x;
    assign wr_point.y = item.data.coord_y;
    assign wr_point.z = item.data.coord_z;

    assign mac_ctl.clr   = accept && is_eval;
    assign mac_ctl.issue = (state_reg == bbse_pkg::ST_WALK);
    assign mac_ctl.last  = (cnt_reg == LAST_IDX);
    assign mac_ctl.idx   = cnt_reg;

    bbse_bern u_bern_u (
        .clk   (clk),
        .load  (mac_ctl.clr),
        .param (item.data.param_u),
        .wgt   (wu)
    );

    bbse_bern u_bern_v (
        .clk   (clk),
        .load  (mac_ctl.clr),
        .param (item.data.param_v),
        .wgt   (wv)
    );

    bbse_ptmem u_ptmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr ({item.data.point_row, item.data.point_col}),
        .wdata (wr_point),
        .re    (mac_ctl.issue),
        .raddr (cnt_reg),
        .rdata (rd_point)
    );

    bbse_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .wu    (wu),
        .wv    (wv),
        .rdata (rd_point),
        .acc_x (acc_x),
        .acc_y (acc_y),
        .acc_z (acc_z),
        .done  (mac_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbse_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            bbse_pkg::ST_IDLE:
            begin
                if (accept && is_eval)
                begin
                    state_next = bbse_pkg::ST_WGT;
                    cnt_next   = '0;
                end
            end
            bbse_pkg::ST_WGT:
            begin
                if (cnt_reg == WGT_LAST)
                begin
                    state_next = bbse_pkg::ST_WALK;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + IB'(1);
                end
            end
            bbse_pkg::ST_WALK:
            begin
                cnt_next = cnt_reg + IB'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = bbse_pkg::ST_DRAIN;
                end
            end
            bbse_pkg::ST_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = bbse_pkg::ST_FIN;
                end
            end
            bbse_pkg::ST_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = bbse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bbse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data_next.surf_x = round_sat(acc_x);
        out_data_next.surf_y = round_sat(acc_y);
        out_data_next.surf_z = round_sat(acc_z);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bbse_pkg::ST_WALK && cnt_reg == LAST_IDX)
            |=> (state_reg == bbse_pkg::ST_DRAIN))
        else $error("point walk did not end after the last point");

    a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == bbse_pkg::ST_DRAIN))
        else $error("accumulator finished outside drain");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> ($past(state_reg) == bbse_pkg::ST_FIN))
        else $error("result word raised without a finished evaluation");

    a_no_load_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (mac_ctl.issue || mac_done) |-> !mem_we)
        else $error("point store written during an evaluation");

endmodule

[hw/rtl/bbse_bern.sv]
// Pipeline for the four cubic Bernstein weights of one parameter.
module bbse_bern (
    input  logic                              clk,
    input  logic                              load,
    input  logic [bbse_pkg::PARAM_BITS-1:0]   param,
    output bbse_pkg::wgt_vec_t                wgt
);

    localparam int PB = bbse_pkg::PARAM_BITS;
    localparam int TB = PB + 2;
    localparam int SB = 2 * PB - 1;
    localparam int AB = 2 * PB - 2;
    localparam int WB = SB + TB;
    localparam int RB = 15;

    logic [PB-1:0] t_clamp;
    logic [PB-1:0] t_reg;
    logic [PB-1:0] a_reg;
    logic [TB-1:0] t3_reg;
    logic [SB-1:0] a2_reg;
    logic [AB-1:0] at3_reg;
    logic [SB-1:0] t2_reg;
    logic [WB-1:0] w_full [4];
    bbse_pkg::wgt_vec_t wgt_reg;

    assign t_clamp = (param > bbse_pkg::ONE_Q15) ? bbse_pkg::ONE_Q15 : param;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            t_reg  <= t_clamp;
            a_reg  <= bbse_pkg::ONE_Q15 - t_clamp;
            t3_reg <= TB'(t_clamp) + TB'({t_clamp, 1'b0});
        end
    end

    always_ff @(posedge clk)
    begin
        a2_reg  <= SB'((2 * PB)'(a_reg) * (2 * PB)'(a_reg));
        at3_reg <= AB'((PB + TB)'(a_reg) * (PB + TB)'(t3_reg));
        t2_reg  <= SB'((2 * PB)'(t_reg) * (2 * PB)'(t_reg));
    end

    always_comb
    begin
        w_full[0] = WB'(a2_reg) * WB'(a_reg);
        w_full[1] = WB'(a2_reg) * WB'(t3_reg);
        w_full[2] = WB'(at3_reg) * WB'(t_reg);
        w_full[3] = WB'(t2_reg) * WB'(t_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            wgt_reg[k] <= bbse_pkg::WGT_BITS'((w_full[k] + (WB'(1) << (RB - 1))) >> RB);
        end
    end

    assign wgt = wgt_reg;

endmodule

[hw/rtl/bbse_ptmem.sv]
// Control point store: 16 words, one write port, one registered read port.
module bbse_ptmem (
    input  logic                             clk,
    input  logic                             we,
    input  logic [bbse_pkg::IDX_BITS-1:0]    waddr,
    input  bbse_pkg::point_t                 wdata,
    input  logic                             re,
    input  logic [bbse_pkg::IDX_BITS-1:0]    raddr,
    output bbse_pkg::point_t                 rdata
);

    bbse_pkg::point_t mem [bbse_pkg::NUM_POINTS];
    bbse_pkg::point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/bbse_mac.sv]
// Weight product, point product and accumulate pipeline over the point walk.
module bbse_mac (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  bbse_pkg::mac_ctl_t                      ctl,
    input  bbse_pkg::wgt_vec_t                      wu,
    input  bbse_pkg::wgt_vec_t                      wv,
    input  bbse_pkg::point_t                        rdata,
    output logic signed [bbse_pkg::ACC_BITS-1:0]    acc_x,
    output logic signed [bbse_pkg::ACC_BITS-1:0]    acc_y,
    output logic signed [bbse_pkg::ACC_BITS-1:0]    acc_z,
    output logic                                    done
);

    localparam int WB = bbse_pkg::WGT_BITS;
    localparam int CB = 2 * WB;
    localparam int PB = bbse_pkg::PROD_BITS;
    localparam int AB = bbse_pkg::ACC_BITS;
    localparam int SB = bbse_pkg::SIDE_BITS;

    logic [CB-1:0]        cw_full;
    logic [WB-1:0]        c_reg;
    logic                 v1_reg;
    logic                 l1_reg;
    logic signed [PB-1:0] cs;
    logic signed [PB-1:0] px_x_reg;
    logic signed [PB-1:0] px_y_reg;
    logic signed [PB-1:0] px_z_reg;
    logic                 v2_reg;
    logic                 l2_reg;
    logic signed [AB-1:0] acc_x_reg;
    logic signed [AB-1:0] acc_y_reg;
    logic signed [AB-1:0] acc_z_reg;
    logic                 done_reg;

    assign cw_full = CB'(wu[ctl.idx[2*SB-1:SB]]) * CB'(wv[ctl.idx[SB-1:0]]);
    assign cs      = PB'($signed({1'b0, c_reg}));

    always_ff @(posedge clk)
    begin
        c_reg <= WB'((cw_full + (CB'(1) << (bbse_pkg::WFRAC - 1))) >> bbse_pkg::WFRAC);
        px_x_reg <= cs * PB'(rdata.x);
        px_y_reg <= cs * PB'(rdata.y);
        px_z_reg <= cs * PB'(rdata.z);
        if (ctl.clr)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_x_reg <= acc_x_reg + AB'(px_x_reg);
            acc_y_reg <= acc_y_reg + AB'(px_y_reg);
            acc_z_reg <= acc_z_reg + AB'(px_z_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            l1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            l2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= ctl.issue;
            l1_reg   <= ctl.issue && ctl.last;
            v2_reg   <= v1_reg;
            l2_reg   <= l1_reg;
            done_reg <= v2_reg && l2_reg;
        end
    end

    assign acc_x = acc_x_reg;
    assign acc_y = acc_y_reg;
    assign acc_z = acc_z_reg;
    assign done  = done_reg;

endmodule

[sim/tb_bicubic_bezier_surface_eval.sv]
// Testbench for the bicubic Bezier surface evaluator: random load/evaluate traffic, scoreboard.
module tb_bicubic_bezier_surface_eval;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 5;
    localparam int RESET_LEN   = 5;
    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_WAIT   = 40;

    class bezier_surface_tracker;
        longint              ctrl_pt [bbse_pkg::NUM_POINTS][3];
        bbse_pkg::out_word_t pending_points [$];
        int                  failures;

        function new();
            failures = 0;
            foreach (ctrl_pt[i, k])
                ctrl_pt[i][k] = 0;
        endfunction

        function void bernstein_weights(input logic [bbse_pkg::PARAM_BITS-1:0] t_in,
                                        output longint unsigned w [4]);
            longint unsigned t;
            longint unsigned a;
            t = (t_in > bbse_pkg::ONE_Q15) ? longint'(bbse_pkg::ONE_Q15) : longint'(t_in);
            a = longint'(bbse_pkg::ONE_Q15) - t;
            w[0] = a * a * a;
            w[1] = 3 * a * a * t;
            w[2] = 3 * a * t * t;
            w[3] = t * t * t;
            for (int k = 0; k < 4; k++)
                w[k] = (w[k] + (64'd1 << 14)) >> 15;
        endfunction

        function logic signed [bbse_pkg::COORD_BITS-1:0] round_clamp(input longint acc);
            longint q;
            longint lo;
            longint hi;
            lo = -(longint'(1) <<< (bbse_pkg::COORD_BITS - 1));
            hi = (longint'(1) <<< (bbse_pkg::COORD_BITS - 1)) - 1;
            q = (acc + (longint'(1) <<< (bbse_pkg::WFRAC - 1))) >>> bbse_pkg::WFRAC;
            if (q < lo)
                q = lo;
            if (q > hi)
                q = hi;
            return q[bbse_pkg::COORD_BITS-1:0];
        endfunction

        function bbse_pkg::out_word_t surface_point(input logic [bbse_pkg::PARAM_BITS-1:0] u,
                                                    input logic [bbse_pkg::PARAM_BITS-1:0] v);
            longint unsigned     wu [4];
            longint unsigned     wv [4];
            longint              acc [3];
            longint              c;
            bbse_pkg::out_word_t r;
            bernstein_weights(u, wu);
            bernstein_weights(v, wv);
            for (int k = 0; k < 3; k++)
                acc[k] = 0;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++)
                begin
                    c = longint'((wu[i] * wv[j] + (64'd1 << (bbse_pkg::WFRAC - 1)))
                                 >> bbse_pkg::WFRAC);
                    for (int k = 0; k < 3; k++)
                        acc[k] += c * ctrl_pt[i * 4 + j][k];
                end
            r.surf_x = round_clamp(acc[0]);
            r.surf_y = round_clamp(acc[1]);
            r.surf_z = round_clamp(acc[2]);
            return r;
        endfunction

        function void note_input(input bbse_pkg::in_word_t w);
            int idx;
            if (w.op == bbse_pkg::OP_EVAL)
                pending_points.push_back(surface_point(w.param_u, w.param_v));
            else
            begin
                idx = {w.point_row, w.point_col};
                ctrl_pt[idx][0] = longint'(signed'(w.coord_x));
                ctrl_pt[idx][1] = longint'(signed'(w.coord_y));
                ctrl_pt[idx][2] = longint'(signed'(w.coord_z));
            end
        endfunction

        function void check_result(input bbse_pkg::out_word_t got);
            bbse_pkg::out_word_t want;
            bit                  bad;
            if (pending_points.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected surface point (%0d,%0d,%0d)",
                             got.surf_x, got.surf_y, got.surf_z);
                return;
            end
            want = pending_points.pop_front();
            bad = 1'b0;
            if (got.surf_x !== want.surf_x)
                bad = 1'b1;
            if (got.surf_y !== want.surf_y)
                bad = 1'b1;
            if (got.surf_z !== want.surf_z)
                bad = 1'b1;
            if (bad)
            begin
                failures++;
                if (failures <= 10)
                    $display("surface point mismatch: want (%0d,%0d,%0d) got (%0d,%0d,%0d)",
                             want.surf_x, want.surf_y, want.surf_z,
                             got.surf_x, got.surf_y, got.surf_z);
            end
        endfunction

        function int outstanding();
            return pending_points.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bbse_in_if  in_ch ();
    bbse_out_if out_ch ();

    bicubic_bezier_surface_eval dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_ch),
        .result (out_ch)
    );

    bezier_surface_tracker tracker = new();

    int quiet_cycles = 0;
    int hold_request;
    bit src_bursts;
    bit sink_bursts;

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        hold_request = 0;
        src_bursts = 1'b0;
        sink_bursts = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_input(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                tracker.check_result(out_ch.data);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                n = hold_request;
                hold_request = 0;
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (sink_bursts && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    function automatic logic signed [bbse_pkg::COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(bbse_pkg::COORD_BITS-1){1'b0}}};
            1: return {1'b0, {(bbse_pkg::COORD_BITS-1){1'b1}}};
            2: return '0;
            default: return bbse_pkg::COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [bbse_pkg::PARAM_BITS-1:0] rand_param();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return bbse_pkg::ONE_Q15;
            2, 3: return bbse_pkg::PARAM_BITS'($urandom_range(32769, 65535));
            default: return bbse_pkg::PARAM_BITS'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic bbse_pkg::in_word_t random_word();
        bbse_pkg::in_word_t w;
        w.op        = ($urandom_range(0, 1) == 1) ? bbse_pkg::OP_EVAL : bbse_pkg::OP_LOAD;
        w.point_row = bbse_pkg::SIDE_BITS'($urandom);
        w.point_col = bbse_pkg::SIDE_BITS'($urandom);
        w.coord_x   = rand_coord();
        w.coord_y   = rand_coord();
        w.coord_z   = rand_coord();
        w.param_u   = rand_param();
        w.param_v   = rand_param();
        return w;
    endfunction

    task automatic send_word(input bbse_pkg::in_word_t w);
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_point(input int row, input int col, input int x, input int y,
                              input int z);
        bbse_pkg::in_word_t w;
        w = random_word();
        w.op        = bbse_pkg::OP_LOAD;
        w.point_row = bbse_pkg::SIDE_BITS'(row);
        w.point_col = bbse_pkg::SIDE_BITS'(col);
        w.coord_x   = bbse_pkg::COORD_BITS'(x);
        w.coord_y   = bbse_pkg::COORD_BITS'(y);
        w.coord_z   = bbse_pkg::COORD_BITS'(z);
        w.param_u   = '1;
        w.param_v   = '1;
        send_word(w);
    endtask

    task automatic eval_point(input int u, input int v);
        bbse_pkg::in_word_t w;
        w = random_word();
        w.op      = bbse_pkg::OP_EVAL;
        w.param_u = bbse_pkg::PARAM_BITS'(u);
        w.param_v = bbse_pkg::PARAM_BITS'(v);
        send_word(w);
    endtask

    task automatic sender_gap();
        if (src_bursts && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole store first: x at max, y at min
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                load_point(i, j, 32767, -32768, $urandom_range(0, 65535));
        eval_point(0, 0);
        eval_point(32768, 32768);
        eval_point(0, 32768);
        eval_point(32768, 0);
        eval_point(16384, 16384);
        eval_point(65535, 40000);
        eval_point(1, 32767);
        load_point(3, 3, -32768, 32767, 0);
        eval_point(32768, 32768);

        for (int blk = 0; blk < 7; blk++)
        begin
            src_bursts  = (blk % 2 == 0);
            sink_bursts = (blk % 3 != 2);
            if (blk == 2)
                hold_request = LONG_HOLD;
            if (blk == 4)
                wait_for_results();
            for (int k = 0; k < 50; k++)
            begin
                send_word(random_word());
                sender_gap();
            end
        end

        // no idling from here on
        src_bursts  = 1'b0;
        sink_bursts = 1'b0;
        for (int k = 0; k < 25; k++)
            send_word(random_word());

        wait_for_results();
        repeat (TAIL_WAIT) @(posedge clk);
        tracker.failures += tracker.outstanding();
        if (tracker.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/bbse_pkg.sv
hw/rtl/bbse_in_if.sv
hw/rtl/bbse_out_if.sv
hw/rtl/bbse_bern.sv
hw/rtl/bbse_ptmem.sv
hw/rtl/bbse_mac.sv
hw/rtl/bicubic_bezier_surface_eval.sv
sim/tb_bicubic_bezier_surface_eval.sv
